// File: src/launcher_fire_and_unjam_control_macros.svh
// ----------------------------------------------------------------------------
// Launcher fire and unjam control assertion macros
// Concurrent assertion wrappers on clk with the synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef LAUNCHER_FIRE_AND_UNJAM_CONTROL_MACROS_SVH
`define LAUNCHER_FIRE_AND_UNJAM_CONTROL_MACROS_SVH

`ifndef SYNTHESIS
`define LFUC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("launcher control assertion failed");
`define LFUC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("launcher control assertion failed");
`else
`define LFUC_ASSERT_SAME(lbl, ante, cons)
`define LFUC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: src/lfuc_pkg.sv
// ----------------------------------------------------------------------------
// Launcher fire and unjam control package
// Field widths, timing constants, switch codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lfuc_pkg;

  localparam int TIME_W   = 32;
  localparam int VAL_W    = 16;
  localparam int MAG_W    = 15;
  localparam int MODE_W   = 2;
  localparam int FLY_W    = 12;
  localparam int TGT_W    = 22;
  localparam int CFG_A_W  = 3;

  localparam logic [TIME_W-1:0] SPIN_UP_MS = 32'd1000;
  localparam logic [TIME_W-1:0] COAST_MS   = 32'd1000;
  localparam logic [FLY_W-1:0]  FLY_RUN_US  = 12'd1300;
  localparam logic [FLY_W-1:0]  FLY_IDLE_US = 12'd400;
  localparam logic signed [TGT_W-1:0] GEAR_FACTOR = 22'sd36;

  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AIMBOT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KILL   = 2'd2;

  typedef enum logic [CFG_A_W-1:0] {
    REG_REMOTE_TIMEOUT = 3'd0,
    REG_JAM_TORQUE     = 3'd1,
    REG_UNJAM_TIME     = 3'd2,
    REG_FEED_SPEED     = 3'd3,
    REG_UNJAM_SPEED    = 3'd4,
    REG_PITCH_OFFSET   = 3'd5,
    REG_YAW_OFFSET     = 3'd6,
    REG_BOX_HALF       = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0]       now_ms;
    logic [TIME_W-1:0]       remote_last_ms;
    logic                    fire_switch;
    logic [MODE_W-1:0]       left_mode;
    logic signed [VAL_W-1:0] target_x;
    logic signed [VAL_W-1:0] target_y;
    logic signed [VAL_W-1:0] torque_zero;
    logic signed [VAL_W-1:0] torque_one;
  } in_word_t;

endpackage

`default_nettype wire

// File: src/lfuc_cfg_if.sv
// ----------------------------------------------------------------------------
// Launcher control configuration channel
// Register write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfuc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lfuc_pkg::CFG_A_W-1:0]   addr;
  logic [lfuc_pkg::VAL_W-1:0]     data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// File: src/lfuc_in_if.sv
// ----------------------------------------------------------------------------
// Launcher control tick channel
// One word per control tick: time, last remote time, switches, target and torques.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfuc_in_if;
  logic                                valid;
  logic                                ready;
  logic [lfuc_pkg::TIME_W-1:0]         now_ms;
  logic [lfuc_pkg::TIME_W-1:0]         remote_last_ms;
  logic                                fire_switch;
  logic [lfuc_pkg::MODE_W-1:0]         left_mode;
  logic signed [lfuc_pkg::VAL_W-1:0]   target_x;
  logic signed [lfuc_pkg::VAL_W-1:0]   target_y;
  logic signed [lfuc_pkg::VAL_W-1:0]   torque_zero;
  logic signed [lfuc_pkg::VAL_W-1:0]   torque_one;

  modport source (output valid, output now_ms, output remote_last_ms, output fire_switch,
                  output left_mode, output target_x, output target_y,
                  output torque_zero, output torque_one, input ready);
  modport sink (input valid, input now_ms, input remote_last_ms, input fire_switch,
                input left_mode, input target_x, input target_y,
                input torque_zero, input torque_one, output ready);
endinterface

`default_nettype wire

// File: src/lfuc_out_if.sv
// ----------------------------------------------------------------------------
// Launcher control result channel
// Flywheel pulse widths, feeder speed targets and the command flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfuc_out_if;
  logic                                valid;
  logic                                ready;
  logic [lfuc_pkg::FLY_W-1:0]          flywheel_a_us;
  logic [lfuc_pkg::FLY_W-1:0]          flywheel_b_us;
  logic signed [lfuc_pkg::TGT_W-1:0]   feeder_zero_target;
  logic signed [lfuc_pkg::TGT_W-1:0]   feeder_one_target;
  logic                                command_issued;

  modport source (output valid, output flywheel_a_us, output flywheel_b_us,
                  output feeder_zero_target, output feeder_one_target,
                  output command_issued, input ready);
  modport sink (input valid, input flywheel_a_us, input flywheel_b_us,
                input feeder_zero_target, input feeder_one_target,
                input command_issued, output ready);
endinterface

`default_nettype wire

// File: src/launcher_fire_and_unjam_control.sv
// ----------------------------------------------------------------------------
// Launcher fire and unjam control
// Flywheel spin-up, feeder jam handling and aim box gating per control tick.
// ----------------------------------------------------------------------------
// The block takes one tick word per clock while the output is not stalled and
// returns one result word per tick: the tick is held in an input register,
// evaluated against the controller state in a single pass, and the result is
// written to an output register together with the state update. A stalled
// output holds one finished word while one more tick waits in the input
// register. Configuration writes are always accepted and take effect on the
// next evaluated tick.
`default_nettype none
`include "launcher_fire_and_unjam_control_macros.svh"

module launcher_fire_and_unjam_control (
  input  wire logic    clk,
  input  wire logic    rst_n,
  lfuc_cfg_if.sink     cfg_ch,
  lfuc_in_if.sink      in_ch,
  lfuc_out_if.source   out_ch
);

  // Configuration registers.
  logic [lfuc_pkg::VAL_W-1:0]        link_silence_r;
  logic [lfuc_pkg::MAG_W-1:0]        jam_torque_r;
  logic [lfuc_pkg::VAL_W-1:0]        unjam_time_r;
  logic signed [lfuc_pkg::VAL_W-1:0] feed_speed_r;
  logic signed [lfuc_pkg::VAL_W-1:0] unjam_speed_r;
  logic signed [lfuc_pkg::VAL_W-1:0] pitch_offset_r;
  logic signed [lfuc_pkg::VAL_W-1:0] yaw_offset_r;
  logic [lfuc_pkg::MAG_W-1:0]        box_half_r;

  // Input stage.
  logic               s1_valid_r;
  lfuc_pkg::in_word_t s1_word_r;
  logic               adv;
  logic               in_ready;
  logic               step;

  // Controller state.
  logic [1:0]                         firing_r, firing_nxt;
  logic [lfuc_pkg::TIME_W-1:0]        spin_start_r [2];
  logic [lfuc_pkg::TIME_W-1:0]        spin_start_nxt [2];
  logic [1:0]                         unjam_r, unjam_nxt;
  logic [lfuc_pkg::TIME_W-1:0]        jam_start_r [2];
  logic [lfuc_pkg::TIME_W-1:0]        jam_start_nxt [2];
  logic [lfuc_pkg::TIME_W-1:0]        last_feed_r, last_feed_nxt;
  logic                               fed_once_r, fed_once_nxt;
  logic [lfuc_pkg::FLY_W-1:0]         held_fly_r, held_fly_nxt;
  logic signed [lfuc_pkg::TGT_W-1:0]  held_t0_r, held_t0_nxt;
  logic signed [lfuc_pkg::TGT_W-1:0]  held_t1_r, held_t1_nxt;
  logic                               issue;

  // Output register.
  logic                               out_valid_r;
  logic [lfuc_pkg::FLY_W-1:0]         out_fly_r;
  logic signed [lfuc_pkg::TGT_W-1:0]  out_t0_r;
  logic signed [lfuc_pkg::TGT_W-1:0]  out_t1_r;
  logic                               out_cmd_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_silence_r   <= 16'd100;
      jam_torque_r     <= 15'd10000;
      unjam_time_r     <= 16'd500;
      feed_speed_r     <= 16'sd60;
      unjam_speed_r    <= -16'sd60;
      pitch_offset_r   <= 16'sd0;
      yaw_offset_r     <= 16'sd0;
      box_half_r       <= 15'd2560;
    end else if (cfg_ch.valid) begin
      case (lfuc_pkg::cfg_reg_t'(cfg_ch.addr))
        lfuc_pkg::REG_REMOTE_TIMEOUT: link_silence_r   <= cfg_ch.data;
        lfuc_pkg::REG_JAM_TORQUE:     jam_torque_r     <= cfg_ch.data[lfuc_pkg::MAG_W-1:0];
        lfuc_pkg::REG_UNJAM_TIME:     unjam_time_r     <= cfg_ch.data;
        lfuc_pkg::REG_FEED_SPEED:     feed_speed_r     <= cfg_ch.data;
        lfuc_pkg::REG_UNJAM_SPEED:    unjam_speed_r    <= cfg_ch.data;
        lfuc_pkg::REG_PITCH_OFFSET:   pitch_offset_r   <= cfg_ch.data;
        lfuc_pkg::REG_YAW_OFFSET:     yaw_offset_r     <= cfg_ch.data;
        lfuc_pkg::REG_BOX_HALF:       box_half_r       <= cfg_ch.data[lfuc_pkg::MAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ready     = !s1_valid_r || adv;
  assign in_ch.ready  = in_ready;
  assign step         = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_word_r <= '{now_ms:         in_ch.now_ms,
                     remote_last_ms: in_ch.remote_last_ms,
                     fire_switch:    in_ch.fire_switch,
                     left_mode:      in_ch.left_mode,
                     target_x:       in_ch.target_x,
                     target_y:       in_ch.target_y,
                     torque_zero:    in_ch.torque_zero,
                     torque_one:     in_ch.torque_one};
    end
  end

  always_comb begin
    logic [lfuc_pkg::TIME_W-1:0]        now;
    logic                               timed_out;
    logic [lfuc_pkg::MODE_W-1:0]        mode_eff;
    logic                               run;
    logic signed [lfuc_pkg::VAL_W:0]    ny;
    logic signed [lfuc_pkg::VAL_W:0]    nx;
    logic [lfuc_pkg::VAL_W:0]           ny_mag;
    logic [lfuc_pkg::VAL_W:0]           nx_mag;
    logic                               in_box;
    logic                               update;
    logic                               coast;
    logic signed [lfuc_pkg::VAL_W-1:0]  tq [2];
    logic [lfuc_pkg::VAL_W-1:0]         tq_mag [2];
    logic [lfuc_pkg::TIME_W-1:0]        start [2];
    logic [lfuc_pkg::TIME_W-1:0]        jstart [2];
    logic [1:0]                         feed;
    logic [1:0]                         jam;
    logic [1:0]                         unj;
    logic [1:0]                         expired;
    logic signed [lfuc_pkg::VAL_W:0]    spd [2];
    logic signed [lfuc_pkg::TGT_W-1:0]  spd_w [2];
    logic signed [lfuc_pkg::TGT_W-1:0]  tgt [2];

    now       = s1_word_r.now_ms;
    timed_out = (now - s1_word_r.remote_last_ms) > {16'd0, link_silence_r};
    mode_eff  = timed_out ? lfuc_pkg::MODE_MANUAL : s1_word_r.left_mode;
    run       = s1_word_r.fire_switch && !timed_out && (mode_eff != lfuc_pkg::MODE_KILL);

    ny     = {s1_word_r.target_y[15], s1_word_r.target_y} + {pitch_offset_r[15], pitch_offset_r};
    nx     = {s1_word_r.target_x[15], s1_word_r.target_x} + {yaw_offset_r[15], yaw_offset_r};
    ny_mag = ny[lfuc_pkg::VAL_W] ? -ny : ny;
    nx_mag = nx[lfuc_pkg::VAL_W] ? -nx : nx;
    in_box = (ny_mag < {2'b00, box_half_r}) && (nx_mag < {2'b00, box_half_r});
    issue  = !(run && (mode_eff == lfuc_pkg::MODE_AIMBOT) && !in_box);
    update = run && issue;

    tq[0] = s1_word_r.torque_zero;
    tq[1] = s1_word_r.torque_one;

    for (int i = 0; i < 2; i++) begin
      tq_mag[i]  = tq[i][lfuc_pkg::VAL_W-1] ? -tq[i] : tq[i];
      start[i]   = firing_r[i] ? spin_start_r[i] : now;
      feed[i]    = update && ((now - start[i]) > lfuc_pkg::SPIN_UP_MS);
      jam[i]     = tq_mag[i] > {1'b0, jam_torque_r};
      jstart[i]  = jam[i] ? now : jam_start_r[i];
      unj[i]     = jam[i] || unjam_r[i];
      expired[i] = (now - jstart[i]) > {16'd0, unjam_time_r};
      spd[i]     = (unj[i] && !expired[i]) ? {unjam_speed_r[15], unjam_speed_r}
                                           : {feed_speed_r[15], feed_speed_r};
      if (i == 0) begin
        spd[i] = -spd[i];
      end
      spd_w[i] = {{(lfuc_pkg::TGT_W - lfuc_pkg::VAL_W - 1){spd[i][lfuc_pkg::VAL_W]}}, spd[i]};
      tgt[i]   = feed[i] ? lfuc_pkg::TGT_W'(spd_w[i] * lfuc_pkg::GEAR_FACTOR) : '0;

      firing_nxt[i]     = update ? 1'b1 : (run ? firing_r[i] : 1'b0);
      spin_start_nxt[i] = update ? start[i] : spin_start_r[i];
      unjam_nxt[i]      = feed[i] ? (unj[i] && !expired[i]) : unjam_r[i];
      jam_start_nxt[i]  = feed[i] ? jstart[i] : jam_start_r[i];
    end

    last_feed_nxt = (|feed) ? now : last_feed_r;
    fed_once_nxt  = fed_once_r || (|feed);

    coast = fed_once_r && ((now - last_feed_r) < lfuc_pkg::COAST_MS) &&
            (mode_eff != lfuc_pkg::MODE_KILL);

    if (update) begin
      held_fly_nxt = lfuc_pkg::FLY_RUN_US;
      held_t0_nxt  = tgt[0];
      held_t1_nxt  = tgt[1];
    end else if (!run) begin
      held_fly_nxt = coast ? lfuc_pkg::FLY_RUN_US : lfuc_pkg::FLY_IDLE_US;
      held_t0_nxt  = '0;
      held_t1_nxt  = '0;
    end else begin
      held_fly_nxt = held_fly_r;
      held_t0_nxt  = held_t0_r;
      held_t1_nxt  = held_t1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      firing_r    <= '0;
      unjam_r     <= '0;
      last_feed_r <= '0;
      fed_once_r  <= 1'b0;
      held_fly_r  <= '0;
      held_t0_r   <= '0;
      held_t1_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        spin_start_r[i] <= '0;
        jam_start_r[i]  <= '0;
      end
    end else begin
      if (step) begin
        firing_r    <= firing_nxt;
        unjam_r     <= unjam_nxt;
        last_feed_r <= last_feed_nxt;
        fed_once_r  <= fed_once_nxt;
        held_fly_r  <= held_fly_nxt;
        held_t0_r   <= held_t0_nxt;
        held_t1_r   <= held_t1_nxt;
        for (int i = 0; i < 2; i++) begin
          spin_start_r[i] <= spin_start_nxt[i];
          jam_start_r[i]  <= jam_start_nxt[i];
        end
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_fly_r <= held_fly_nxt;
      out_t0_r  <= held_t0_nxt;
      out_t1_r  <= held_t1_nxt;
      out_cmd_r <= issue;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.flywheel_a_us      = out_fly_r;
  assign out_ch.flywheel_b_us      = out_fly_r;
  assign out_ch.feeder_zero_target = out_t0_r;
  assign out_ch.feeder_one_target  = out_t1_r;
  assign out_ch.command_issued     = out_cmd_r;

  `LFUC_ASSERT_SAME(a_feed_needs_run, out_valid_r && (out_t0_r != '0 || out_t1_r != '0), out_fly_r == lfuc_pkg::FLY_RUN_US)
  `LFUC_ASSERT_SAME(a_fly_legal, out_valid_r, out_fly_r == '0 || out_fly_r == lfuc_pkg::FLY_RUN_US || out_fly_r == lfuc_pkg::FLY_IDLE_US)
  `LFUC_ASSERT_SAME(a_fed_once_sticky, $past(rst_n), !$fell(fed_once_r))
  `LFUC_ASSERT_NEXT(a_step_loads_out, step, out_valid_r)

endmodule

`default_nettype wire
